/* rtl/afk_pkg.sv */
package afk_pkg;

	// internal angle width, Q30 radians, holds the widest joint sum
	localparam int ZW = 36;
	// CORDIC x/y datapath width
	localparam int XW = 33;
	// sine/cosine width after the rotator
	localparam int TW = 32;
	// link length register width
	localparam int LW = 20;
	// position output width
	localparam int PW = 24;
	// configuration index width
	localparam int CFG_IW = 3;

	localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_LATERAL = 3'd0;
	localparam logic [CFG_IW-1:0] REG_UPPER   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_FORE    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_HAND    = 3'd3;

	typedef struct packed {
		logic signed [LW-1:0] lateral;
		logic signed [LW-1:0] upper;
		logic signed [LW-1:0] fore;
		logic signed [LW-1:0] hand;
	} cfg_t;

	typedef struct packed {
		logic signed [ZW-1:0] z;
		logic                 flip;
	} red_t;

	// arctangent table, Q30
	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] t);
		logic signed [ZW-1:0] r;
		case (t)
			5'd0:    r = 36'sd843314857;
			5'd1:    r = 36'sd497837829;
			5'd2:    r = 36'sd263043837;
			5'd3:    r = 36'sd133525159;
			5'd4:    r = 36'sd67021687;
			5'd5:    r = 36'sd33543516;
			5'd6:    r = 36'sd16775851;
			5'd7:    r = 36'sd8388437;
			5'd8:    r = 36'sd4194283;
			5'd9:    r = 36'sd2097149;
			5'd31:   r = 36'sd0;
			default: r = ZW'(64'sd1 <<< (30 - t));
		endcase
		return r;
	endfunction

	// fold into [-pi, pi], then into [-pi/2, pi/2] with a sign flip
	function automatic red_t reduce(input logic signed [ZW-1:0] a);
		logic signed [ZW-1:0] v;
		red_t r;
		v = a;
		for (int k = 0; k < 4; k++) begin
			if (v > PI_Q30) v = v - TWO_PI_Q30;
			else if (v < -PI_Q30) v = v + TWO_PI_Q30;
		end
		r.flip = 1'b0;
		if (v > HALF_PI_Q30) begin
			v = v - PI_Q30;
			r.flip = 1'b1;
		end else if (v < -HALF_PI_Q30) begin
			v = v + PI_Q30;
			r.flip = 1'b1;
		end
		r.z = v;
		return r;
	endfunction

	// clamp to the position range
	function automatic logic signed [PW-1:0] sat_pos(input logic signed [39:0] v);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		hi = 40'sd8388607;
		lo = -40'sd8388608;
		if (v > hi) return PW'(hi);
		else if (v < lo) return PW'(lo);
		else return v[PW-1:0];
	endfunction

endpackage

/* rtl/afk_in_if.sv */
interface afk_in_if #(parameter int ANGLE_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] base_angle;
	logic signed [ANGLE_WIDTH-1:0] shoulder_angle;
	logic signed [ANGLE_WIDTH-1:0] elbow_angle;
	logic signed [ANGLE_WIDTH-1:0] wrist_angle;

	modport source (output valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
		input ready);
	modport sink (input valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
		output ready);
endinterface

/* rtl/afk_out_if.sv */
interface afk_out_if #(parameter int ANGLE_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [23:0]            pos_x;
	logic signed [23:0]            pos_y;
	logic signed [23:0]            pos_z;
	logic signed [ANGLE_WIDTH+1:0] tool_pitch;

	modport source (output valid, pos_x, pos_y, pos_z, tool_pitch, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, tool_pitch, output ready);
endinterface

/* rtl/afk_cfg_if.sv */
interface afk_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [19:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/afk_prep.sv */
module afk_prep #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic signed [ANGLE_WIDTH-1:0] base_angle,
	input  logic signed [ANGLE_WIDTH-1:0] shoulder_angle,
	input  logic signed [ANGLE_WIDTH-1:0] elbow_angle,
	input  logic signed [ANGLE_WIDTH-1:0] wrist_angle,
	output logic                          out_valid,
	output afk_pkg::red_t                 red [4],
	output logic signed [ANGLE_WIDTH+1:0] pitch
);
	localparam int SW = ANGLE_WIDTH + 2;
	localparam int WIDEN = 33 - ANGLE_WIDTH;

	logic signed [SW-1:0] sum2, sum3;
	logic signed [afk_pkg::ZW-1:0] ang_s1 [4];
	logic signed [SW-1:0] pitch_s1, pitch_s2;
	logic v_s1, v_s2;
	afk_pkg::red_t red_s2 [4];

	// joint sums, exact in two extra bits
	assign sum2 = SW'(shoulder_angle) + SW'(elbow_angle);
	assign sum3 = sum2 + SW'(wrist_angle);

	// stage 1: widen to Q30
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1[0] <= afk_pkg::ZW'(base_angle) <<< WIDEN;
			ang_s1[1] <= afk_pkg::ZW'(shoulder_angle) <<< WIDEN;
			ang_s1[2] <= afk_pkg::ZW'(sum2) <<< WIDEN;
			ang_s1[3] <= afk_pkg::ZW'(sum3) <<< WIDEN;
			pitch_s1  <= -sum3;
		end
	end

	// stage 2: range reduction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 4; l++) red_s2[l] <= afk_pkg::reduce(ang_s1[l]);
			pitch_s2 <= pitch_s1;
		end
	end

	assign out_valid = v_s2;
	assign red = red_s2;
	assign pitch = pitch_s2;
endmodule

/* rtl/afk_cordic.sv */
module afk_cordic #(
	parameter int ANGLE_WIDTH = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  afk_pkg::red_t                 red [4],
	input  logic signed [ANGLE_WIDTH+1:0] pitch_in,
	output logic                          out_valid,
	output logic signed [afk_pkg::TW-1:0] cos_out [4],
	output logic signed [afk_pkg::TW-1:0] sin_out [4],
	output logic signed [ANGLE_WIDTH+1:0] pitch_out
);
	localparam int N = CORDIC_STAGES;

	logic signed [afk_pkg::XW-1:0] x_s [1:N][4];
	logic signed [afk_pkg::XW-1:0] y_s [1:N][4];
	logic signed [afk_pkg::ZW-1:0] z_s [1:N][4];
	logic [3:0]                    flip_s [1:N];
	logic signed [ANGLE_WIDTH+1:0] pitch_s [1:N];
	logic                          v_s [1:N];

	// one micro-rotation per stage, four lanes side by side
	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [4:0] T = 5'(k);
		logic signed [afk_pkg::XW-1:0] x_in [4];
		logic signed [afk_pkg::XW-1:0] y_in [4];
		logic signed [afk_pkg::ZW-1:0] z_in [4];
		logic [3:0]                    flip_in;
		logic signed [ANGLE_WIDTH+1:0] pitch_at;
		logic                          v_in;

		// first stage starts from the reduced input
		if (k == 0) begin : g_head
			always_comb begin
				for (int l = 0; l < 4; l++) begin
					x_in[l] = afk_pkg::GAIN_Q30;
					y_in[l] = '0;
					z_in[l] = red[l].z;
					flip_in[l] = red[l].flip;
				end
				pitch_at = pitch_in;
				v_in = in_valid;
			end
		end else begin : g_tail
			always_comb begin
				for (int l = 0; l < 4; l++) begin
					x_in[l] = x_s[k][l];
					y_in[l] = y_s[k][l];
					z_in[l] = z_s[k][l];
				end
				flip_in = flip_s[k];
				pitch_at = pitch_s[k];
				v_in = v_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 4; l++) begin
					if (z_in[l] >= 0) begin
						x_s[k+1][l] <= x_in[l] - (y_in[l] >>> T);
						y_s[k+1][l] <= y_in[l] + (x_in[l] >>> T);
						z_s[k+1][l] <= z_in[l] - afk_pkg::atan_q30(T);
					end else begin
						x_s[k+1][l] <= x_in[l] + (y_in[l] >>> T);
						y_s[k+1][l] <= y_in[l] - (x_in[l] >>> T);
						z_s[k+1][l] <= z_in[l] + afk_pkg::atan_q30(T);
					end
				end
				flip_s[k+1] <= flip_in;
				pitch_s[k+1] <= pitch_at;
			end
		end
	end

	// undo the half-turn fold
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			cos_out[l] = flip_s[N][l] ? afk_pkg::TW'(-x_s[N][l]) : afk_pkg::TW'(x_s[N][l]);
			sin_out[l] = flip_s[N][l] ? afk_pkg::TW'(-y_s[N][l]) : afk_pkg::TW'(y_s[N][l]);
		end
	end

	assign out_valid = v_s[N];
	assign pitch_out = pitch_s[N];
endmodule

/* rtl/afk_mult.sv */
module afk_mult #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  afk_pkg::cfg_t                 cfg,
	input  logic signed [afk_pkg::TW-1:0] cos_in [4],
	input  logic signed [afk_pkg::TW-1:0] sin_in [4],
	input  logic signed [ANGLE_WIDTH+1:0] pitch_in,
	output logic                          out_valid,
	output logic signed [23:0]            pos_x,
	output logic signed [23:0]            pos_y,
	output logic signed [23:0]            pos_z,
	output logic signed [ANGLE_WIDTH+1:0] tool_pitch
);
	localparam int TW = afk_pkg::TW;
	localparam int LW = afk_pkg::LW;
	localparam int PW = afk_pkg::PW;
	localparam int P1W = LW + TW;
	localparam int S1W = P1W + 2;
	localparam int RW = 33;
	localparam int OW = LW + 8;
	localparam int P3W = RW + TW;
	localparam int S3W = P3W + 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [P1W-1:0] pc2_s1, pc23_s1, pc234_s1, ps2_s1, ps23_s1, ps234_s1;
	logic signed [TW-1:0]  c1_s1, s1_s1, c1_s2, s1_s2;
	logic signed [ANGLE_WIDTH+1:0] pitch_s1, pitch_s2, pitch_s3, pitch_s4;
	logic signed [S1W-1:0] reach_sum, z_sum;
	logic signed [RW-1:0]  reach_s2;
	logic signed [PW-1:0]  pz_s2, pz_s3, pz_s4;
	logic signed [OW-1:0]  lat_sh;
	logic signed [P3W-1:0] rc_s3, rs_s3, lc_s3, ls_s3;
	logic signed [S3W-1:0] x_sum, y_sum;
	logic signed [PW-1:0]  px_s4, py_s4;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: link length times trig terms
	always_ff @(posedge clk) begin
		if (adv) begin
			pc2_s1   <= P1W'(cfg.upper) * P1W'(cos_in[1]);
			pc23_s1  <= P1W'(cfg.fore) * P1W'(cos_in[2]);
			pc234_s1 <= P1W'(cfg.hand) * P1W'(cos_in[3]);
			ps2_s1   <= P1W'(cfg.upper) * P1W'(sin_in[1]);
			ps23_s1  <= P1W'(cfg.fore) * P1W'(sin_in[2]);
			ps234_s1 <= P1W'(cfg.hand) * P1W'(sin_in[3]);
			c1_s1    <= cos_in[0];
			s1_s1    <= sin_in[0];
			pitch_s1 <= pitch_in;
		end
	end

	// stage 2: reach and height, rounded
	assign reach_sum = S1W'(pc23_s1) + S1W'(pc2_s1) + S1W'(pc234_s1) + (S1W'(1) <<< 21);
	assign z_sum = S1W'(ps23_s1) + S1W'(ps2_s1) + S1W'(ps234_s1) + (S1W'(1) <<< 29);

	always_ff @(posedge clk) begin
		if (adv) begin
			reach_s2 <= RW'(reach_sum >>> 22);
			pz_s2    <= afk_pkg::sat_pos(40'(z_sum >>> 30));
			c1_s2    <= c1_s1;
			s1_s2    <= s1_s1;
			pitch_s2 <= pitch_s1;
		end
	end

	// stage 3: rotate reach and offset by the base angle
	assign lat_sh = {cfg.lateral, 8'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			rc_s3    <= P3W'(reach_s2) * P3W'(c1_s2);
			rs_s3    <= P3W'(reach_s2) * P3W'(s1_s2);
			lc_s3    <= P3W'(lat_sh) * P3W'(c1_s2);
			ls_s3    <= P3W'(lat_sh) * P3W'(s1_s2);
			pz_s3    <= pz_s2;
			pitch_s3 <= pitch_s2;
		end
	end

	// stage 4: round, clamp, hold for the sink
	assign x_sum = S3W'(rc_s3) - S3W'(ls_s3) + (S3W'(1) <<< 37);
	assign y_sum = S3W'(rs_s3) + S3W'(lc_s3) + (S3W'(1) <<< 37);

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4    <= afk_pkg::sat_pos(40'(x_sum >>> 38));
			py_s4    <= afk_pkg::sat_pos(40'(y_sum >>> 38));
			pz_s4    <= pz_s3;
			pitch_s4 <= pitch_s3;
		end
	end

	assign out_valid  = v_s4;
	assign pos_x      = px_s4;
	assign pos_y      = py_s4;
	assign pos_z      = pz_s4;
	assign tool_pitch = pitch_s4;
endmodule

/* rtl/arm_forward_kinematics_top.sv */
// Forward kinematics of a four-joint arm.
// joint_in: one beat carries base, shoulder, elbow and wrist angles, Q3.(ANGLE_WIDTH-3)
// radians. pose_out: one beat per input beat with x, y, z (mm, 8 fractional bits,
// saturated to 24 bits) and tool pitch, the negated sum of the last three angles.
// cfg: writes the four link registers by index (0 lateral offset, 1 upper arm,
// 2 forearm, 3 hand); it is always ready, higher indexes are dropped. Write only
// while no beats are in flight.
// The pipeline runs angle sums and range folding, then the CORDIC micro-rotations
// (four lanes in parallel), then multiply, round and clamp. A new beat is taken
// every cycle unless the sink stalls.
// When the sink stalls, the whole pipeline holds; joint_in.ready drops only while
// a result sits unread in the output stage. Reset clears all valid bits and sets
// the link registers to zero.
module arm_forward_kinematics_top #(
	parameter int ANGLE_WIDTH = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	afk_in_if.sink    joint_in,
	afk_out_if.source pose_out,
	afk_cfg_if.sink   cfg
);
	logic adv;
	afk_pkg::cfg_t cfg_q;
	logic prep_valid, cor_valid;
	afk_pkg::red_t red [4];
	logic signed [ANGLE_WIDTH+1:0] prep_pitch, cor_pitch;
	logic signed [afk_pkg::TW-1:0] cos_v [4];
	logic signed [afk_pkg::TW-1:0] sin_v [4];

	// pipeline moves when the output stage is empty or being read
	assign adv = !pose_out.valid || pose_out.ready;
	assign joint_in.ready = adv;
	assign cfg.ready = 1'b1;

	// link registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				afk_pkg::REG_LATERAL: cfg_q.lateral <= cfg.data;
				afk_pkg::REG_UPPER:   cfg_q.upper <= cfg.data;
				afk_pkg::REG_FORE:    cfg_q.fore <= cfg.data;
				afk_pkg::REG_HAND:    cfg_q.hand <= cfg.data;
				default: ;
			endcase
		end
	end

	afk_prep #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_prep (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(joint_in.valid),
		.base_angle(joint_in.base_angle),
		.shoulder_angle(joint_in.shoulder_angle),
		.elbow_angle(joint_in.elbow_angle),
		.wrist_angle(joint_in.wrist_angle),
		.out_valid(prep_valid), .red(red), .pitch(prep_pitch)
	);

	afk_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(prep_valid), .red(red), .pitch_in(prep_pitch),
		.out_valid(cor_valid), .cos_out(cos_v), .sin_out(sin_v), .pitch_out(cor_pitch)
	);

	afk_mult #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_mult (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(cor_valid), .cfg(cfg_q),
		.cos_in(cos_v), .sin_in(sin_v), .pitch_in(cor_pitch),
		.out_valid(pose_out.valid),
		.pos_x(pose_out.pos_x), .pos_y(pose_out.pos_y), .pos_z(pose_out.pos_z),
		.tool_pitch(pose_out.tool_pitch)
	);
endmodule
